### design/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### design/oble_pkg.sv
`default_nettype none

package oble_pkg;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OUT_POS_W = 7;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W =
    ((STAT_W + OUT_POS_W + VAL_W + OUT_CNT_W + 7) / 8) * 8;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam cmd_t CMD_APPEND = cmd_t'(0);
  localparam cmd_t CMD_INSERT = cmd_t'(1);
  localparam cmd_t CMD_POP    = cmd_t'(2);
  localparam cmd_t CMD_SEARCH = cmd_t'(3);
  localparam cmd_t CMD_CLEAR  = cmd_t'(4);

  localparam stat_t ST_OK    = stat_t'(0);
  localparam stat_t ST_FULL  = stat_t'(1);
  localparam stat_t ST_EMPTY = stat_t'(2);

  typedef enum logic [2:0] {
    OP_ADD,
    OP_POP,
    OP_SEARCH,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic take_pop;
    logic rd_en;
    logic wr_back;
    logic wr_val;
    logic ptr_inc;
    logic ptr_dec;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_found;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic more;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

### design/oble_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module oble_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [oble_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire oble_pkg::cmd_t                 in_cmd_i,
  input  wire oble_pkg::ctl_t                 ctl_i,
  output oble_pkg::sts_t                      sts_o,
  output logic [oble_pkg::OUT_DATA_W-1:0]     out_data_o
);

  logic [oble_pkg::VAL_W-1:0] mem [oble_pkg::LIST_DEPTH];

  oble_pkg::op_e                   op_q, op_d;
  logic [oble_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [oble_pkg::CNT_W-1:0]      ptr_q, ptr_d;
  logic [oble_pkg::CNT_W-1:0]      tgt_q, tgt_d;
  logic [oble_pkg::VAL_W-1:0]      val_q;
  logic [oble_pkg::VAL_W-1:0]      rdata_q;
  logic [oble_pkg::VAL_W-1:0]      popped_q;
  logic [oble_pkg::OUT_POS_W-1:0]  found_q, found_d;
  oble_pkg::stat_t                 status_q;
  logic [oble_pkg::OUT_DATA_W-1:0] out_q;

  logic [oble_pkg::VAL_W-1:0]  in_val;
  logic [oble_pkg::POS_W-1:0]  in_pos;
  logic [oble_pkg::CMP_W-1:0]  pos_x;
  logic [oble_pkg::CMP_W-1:0]  cnt_x;
  oble_pkg::op_e               load_op;
  logic [oble_pkg::CNT_W-1:0]  ins_tgt;
  oble_pkg::stat_t             load_status;
  logic                        full;
  logic                        empty;
  logic [oble_pkg::CNT_W-1:0]  ptr_m1;
  logic [oble_pkg::ADDR_W-1:0] rd_addr;
  logic [oble_pkg::ADDR_W-1:0] wr_addr;
  logic [oble_pkg::VAL_W-1:0]  wr_data;

  assign in_val = in_data_i[oble_pkg::VAL_W-1:0];
  assign in_pos = in_data_i[oble_pkg::VAL_W+oble_pkg::POS_W-1:oble_pkg::VAL_W];
  assign pos_x  = oble_pkg::CMP_W'(in_pos);
  assign cnt_x  = oble_pkg::CMP_W'(cnt_q);
  assign full   = (cnt_q == oble_pkg::CNT_W'(oble_pkg::LIST_DEPTH));
  assign empty  = (cnt_q == '0);
  assign ptr_m1 = ptr_q - oble_pkg::CNT_W'(1);

  always_comb begin
    unique case (in_cmd_i)
      oble_pkg::CMD_APPEND: load_op = oble_pkg::OP_ADD;
      oble_pkg::CMD_INSERT: load_op = oble_pkg::OP_ADD;
      oble_pkg::CMD_POP:    load_op = oble_pkg::OP_POP;
      oble_pkg::CMD_SEARCH: load_op = oble_pkg::OP_SEARCH;
      oble_pkg::CMD_CLEAR:  load_op = oble_pkg::OP_CLEAR;
      default:              load_op = oble_pkg::OP_NOP;
    endcase
  end

  // Target slot of a new byte. A plain append and any insert at or past the
  // tail land at the count.
  always_comb begin
    priority if (in_cmd_i != oble_pkg::CMD_INSERT || empty || pos_x >= cnt_x) begin
      ins_tgt = cnt_q;
    end else if (pos_x <= oble_pkg::CMP_W'(1)) begin
      ins_tgt = '0;
    end else begin
      ins_tgt = oble_pkg::CNT_W'(pos_x - oble_pkg::CMP_W'(1));
    end
  end

  always_comb begin
    priority if (load_op == oble_pkg::OP_ADD && full) begin
      load_status = oble_pkg::ST_FULL;
    end else if (load_op == oble_pkg::OP_POP && empty) begin
      load_status = oble_pkg::ST_EMPTY;
    end else begin
      load_status = oble_pkg::ST_OK;
    end
  end

  always_comb begin
    op_d  = op_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    tgt_d = tgt_q;
    if (ctl_i.load) begin
      op_d  = load_op;
      tgt_d = ins_tgt;
      unique case (load_op)
        oble_pkg::OP_ADD: ptr_d = cnt_q;
        oble_pkg::OP_POP: ptr_d = oble_pkg::CNT_W'(1);
        default:          ptr_d = '0;
      endcase
    end
    if (ctl_i.ptr_inc) begin
      ptr_d = ptr_q + oble_pkg::CNT_W'(1);
    end
    if (ctl_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
    if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + oble_pkg::CNT_W'(1);
    end
    if (ctl_i.cnt_dec) begin
      cnt_d = cnt_q - oble_pkg::CNT_W'(1);
    end
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    found_d = found_q;
    if (ctl_i.load) begin
      found_d = '0;
    end
    if (ctl_i.set_found) begin
      found_d = oble_pkg::OUT_POS_W'(ptr_q + oble_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= oble_pkg::OP_NOP;
      cnt_q <= '0;
      ptr_q <= '0;
      tgt_q <= '0;
    end else begin
      op_q  <= op_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      tgt_q <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    if (ctl_i.load) begin
      val_q    <= in_val;
      status_q <= load_status;
      popped_q <= '0;
    end
    if (ctl_i.take_pop) begin
      popped_q <= rdata_q;
    end
    // The result is held here so that the next command can run while it waits.
    if (ctl_i.emit) begin
      out_q <= oble_pkg::OUT_DATA_W'({oble_pkg::OUT_CNT_W'(cnt_d), popped_q,
                                      found_d, status_q});
    end
  end

  // Shifts move one byte per read/write pair: insert walks down from the
  // tail, pop walks up from the second entry.
  always_comb begin
    if (ctl_i.load) begin
      rd_addr = '0;
    end else if (op_q == oble_pkg::OP_ADD) begin
      rd_addr = ptr_m1[oble_pkg::ADDR_W-1:0];
    end else begin
      rd_addr = ptr_q[oble_pkg::ADDR_W-1:0];
    end
    if (ctl_i.wr_val || op_q == oble_pkg::OP_ADD) begin
      wr_addr = ptr_q[oble_pkg::ADDR_W-1:0];
    end else begin
      wr_addr = ptr_m1[oble_pkg::ADDR_W-1:0];
    end
    wr_data = ctl_i.wr_val ? val_q : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_val || ctl_i.wr_back) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en || ctl_i.load) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    sts_o.op    = op_q;
    sts_o.full  = full;
    sts_o.empty = empty;
    sts_o.more  = (op_q == oble_pkg::OP_ADD) ? (ptr_q > tgt_q) : (ptr_q < cnt_q);
    sts_o.hit   = (rdata_q == val_q);
  end

  assign out_data_o = out_q;

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni,
                cnt_q > oble_pkg::CNT_W'(oble_pkg::LIST_DEPTH), "count above depth")
  `ASSERT_PROP(a_inc_not_full, clk_i, rst_ni, ctl_i.cnt_inc |-> !full,
               "count raised on a full list")
  `ASSERT_PROP(a_dec_not_empty, clk_i, rst_ni, ctl_i.cnt_dec |-> !empty,
               "count lowered on an empty list")
  `ASSERT_PROP(a_add_ptr_bound, clk_i, rst_ni,
               (op_q == oble_pkg::OP_ADD && ctl_i.wr_back) |-> (ptr_q > tgt_q),
               "insert shift past its target")

endmodule

`default_nettype wire

### design/oble_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module oble_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire oble_pkg::sts_t sts_i,
  output oble_pkg::ctl_t      ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_CHECK,
    S_MOVE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   done;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    done    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.load = 1'b1;
          state_d    = S_HEAD;
        end
      end
      // The head byte was read during the load cycle.
      S_HEAD: begin
        if (sts_i.op == oble_pkg::OP_POP && !sts_i.empty) begin
          ctl_o.take_pop = 1'b1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (sts_i.op)
          oble_pkg::OP_ADD: begin
            if (sts_i.full) begin
              done = 1'b1;
            end else if (sts_i.more) begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_MOVE;
            end else begin
              ctl_o.wr_val  = 1'b1;
              ctl_o.cnt_inc = 1'b1;
              done          = 1'b1;
            end
          end
          oble_pkg::OP_POP: begin
            if (sts_i.empty) begin
              done = 1'b1;
            end else if (sts_i.more) begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_MOVE;
            end else begin
              ctl_o.cnt_dec = 1'b1;
              done          = 1'b1;
            end
          end
          oble_pkg::OP_SEARCH: begin
            if (sts_i.more) begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_MOVE;
            end else begin
              done = 1'b1;
            end
          end
          oble_pkg::OP_CLEAR: begin
            ctl_o.cnt_clr = 1'b1;
            done          = 1'b1;
          end
          oble_pkg::OP_NOP: begin
            done = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_MOVE: begin
        unique case (sts_i.op)
          oble_pkg::OP_ADD: begin
            ctl_o.wr_back = 1'b1;
            ctl_o.ptr_dec = 1'b1;
            state_d       = S_CHECK;
          end
          oble_pkg::OP_POP: begin
            ctl_o.wr_back = 1'b1;
            ctl_o.ptr_inc = 1'b1;
            state_d       = S_CHECK;
          end
          oble_pkg::OP_SEARCH: begin
            if (sts_i.hit) begin
              ctl_o.set_found = 1'b1;
              done            = 1'b1;
            end else begin
              ctl_o.ptr_inc = 1'b1;
              state_d       = S_CHECK;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // The finishing step waits, with no side effects, until the previous
    // result has been taken.
    if (done && !out_free) begin
      ctl_o   = '0;
      state_d = state_q;
      done    = 1'b0;
    end
    ctl_o.emit = done;
    if (done) begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_PROP(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q == S_HEAD),
               "accepted command did not start")
  `ASSERT_NEVER(a_one_write, clk_i, rst_ni, ctl_o.wr_val && ctl_o.wr_back,
                "two writes in one cycle")
  `ASSERT_PROP(a_result_held, clk_i, rst_ni, (out_valid_q && !out_ready_i) |=> out_valid_q,
               "waiting result dropped")
  `ASSERT_PROP(a_result_after_done, clk_i, rst_ni, done |=> out_valid_q,
               "finished command gave no result")

endmodule

`default_nettype wire

### design/ordered_byte_list_engine.sv
// An accepted command is loaded, then passes a head state and a check state; each byte moved
// or compared adds a move state and a return to check: insert moves count - slot bytes, pop
// count - 1, and search compares up to its position on a hit, ending in move, or all on a miss.
// One command at a time: the next is accepted once the last has finished. A result waits in
// its own output register; a command that finishes while it is untaken stalls until then.
// Reset clears the count and the output valid; the list memory is not cleared.
`default_nettype none

module ordered_byte_list_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // item_value [7:0], position [14:8], zero [15]
  input  wire logic [oble_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // cmd [2:0]
  input  wire logic [oble_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // status [1:0], found_position [8:2], popped_value [16:9], element_count [23:17]
  output logic [oble_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  oble_pkg::ctl_t ctl;
  oble_pkg::sts_t sts;

  oble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  oble_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .in_cmd_i   (s_axis_tuser_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### verif/ordered_byte_list_engine_tb.sv
`default_nettype none

module ordered_byte_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1680;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 2 * oble_pkg::LIST_DEPTH + 8;
  localparam int unsigned NUM_ROWS     = 21;

  // Command codes the block treats as no-ops; each still gets a reply.
  localparam oble_pkg::cmd_t CMD_RSVD_A = oble_pkg::cmd_t'(5);
  localparam oble_pkg::cmd_t CMD_RSVD_B = oble_pkg::cmd_t'(6);
  localparam oble_pkg::cmd_t CMD_RSVD_C = oble_pkg::cmd_t'(7);

  typedef struct packed {
    oble_pkg::stat_t                  status;
    logic [oble_pkg::OUT_POS_W-1:0]   found;
    logic [oble_pkg::VAL_W-1:0]       popped;
    logic [oble_pkg::OUT_CNT_W-1:0]   count;
  } reply_t;

  typedef struct packed {
    oble_pkg::cmd_t                   cmd;
    logic [oble_pkg::VAL_W-1:0]       value;
    logic [oble_pkg::POS_W-1:0]       pos;
    logic                             typed;
    reply_t                           want;
  } row_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [oble_pkg::IN_DATA_W-1:0]     s_tdata = '0;
  logic [oble_pkg::CMD_W-1:0]         s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [oble_pkg::OUT_DATA_W-1:0]    m_tdata;

  logic [oble_pkg::VAL_W-1:0] list_mirror [$];
  reply_t                     expected_replies [$];
  int unsigned                mismatches = 0;
  int unsigned                quiet_cycles = 0;
  bit                         tx_idle_on = 1'b1;
  bit                         rx_idle_on = 1'b1;

  // Directed rows; rows with typed set carry the reply that is obvious by hand.
  row_t plan [NUM_ROWS] = '{
    '{oble_pkg::CMD_POP,    8'h00, 7'd0,   1'b1, '{oble_pkg::ST_EMPTY, 7'd0, 8'h00, 7'd0}},
    '{oble_pkg::CMD_SEARCH, 8'h00, 7'd0,   1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd0}},
    '{oble_pkg::CMD_INSERT, 8'hAA, 7'd5,   1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd1}},
    '{oble_pkg::CMD_APPEND, 8'h00, 7'd0,   1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd2}},
    '{oble_pkg::CMD_INSERT, 8'hFF, 7'd0,   1'b0, '0},
    '{oble_pkg::CMD_INSERT, 8'h55, 7'd1,   1'b0, '0},
    '{oble_pkg::CMD_INSERT, 8'h11, 7'd4,   1'b0, '0},
    '{oble_pkg::CMD_INSERT, 8'h22, 7'd127, 1'b0, '0},
    '{oble_pkg::CMD_INSERT, 8'h80, 7'd3,   1'b0, '0},
    '{oble_pkg::CMD_SEARCH, 8'hFF, 7'd0,   1'b0, '0},
    '{oble_pkg::CMD_SEARCH, 8'h22, 7'd64,  1'b0, '0},
    '{oble_pkg::CMD_SEARCH, 8'h7E, 7'd0,   1'b0, '0},
    '{oble_pkg::CMD_POP,    8'hFF, 7'd127, 1'b0, '0},
    '{CMD_RSVD_A,           8'hFF, 7'd127, 1'b0, '0},
    '{CMD_RSVD_B,           8'h5A, 7'd42,  1'b0, '0},
    '{CMD_RSVD_C,           8'hA5, 7'd85,  1'b0, '0},
    '{oble_pkg::CMD_SEARCH, 8'h00, 7'd0,   1'b0, '0},
    '{oble_pkg::CMD_CLEAR,  8'hFF, 7'd127, 1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd0}},
    '{oble_pkg::CMD_POP,    8'h00, 7'd0,   1'b1, '{oble_pkg::ST_EMPTY, 7'd0, 8'h00, 7'd0}},
    '{oble_pkg::CMD_INSERT, 8'h01, 7'd1,   1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd1}},
    '{oble_pkg::CMD_CLEAR,  8'h00, 7'd0,   1'b1, '{oble_pkg::ST_OK,    7'd0, 8'h00, 7'd0}}
  };

  ordered_byte_list_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the mirrored list and returns the reply it gives.
  function automatic reply_t apply_command(input oble_pkg::cmd_t cmd,
                                           input logic [oble_pkg::VAL_W-1:0] value,
                                           input logic [oble_pkg::POS_W-1:0] pos);
    reply_t r;
    int     slot;
    int     n;
    r = '0;
    r.status = oble_pkg::ST_OK;
    n = list_mirror.size();
    case (cmd)
      oble_pkg::CMD_APPEND, oble_pkg::CMD_INSERT: begin
        if (n >= oble_pkg::LIST_DEPTH) begin
          r.status = oble_pkg::ST_FULL;
        end else begin
          if (cmd == oble_pkg::CMD_APPEND || n == 0 || int'(pos) >= n) slot = n;
          else if (pos <= 1) slot = 0;
          else slot = int'(pos) - 1;
          list_mirror.insert(slot, value);
        end
      end
      oble_pkg::CMD_POP: begin
        if (n == 0) r.status = oble_pkg::ST_EMPTY;
        else r.popped = list_mirror.pop_front();
      end
      oble_pkg::CMD_SEARCH: begin
        for (int i = 0; i < n; i++)
          if (r.found == '0 && list_mirror[i] == value)
            r.found = oble_pkg::OUT_POS_W'(i + 1);
      end
      oble_pkg::CMD_CLEAR: list_mirror.delete();
      default: ;
    endcase
    r.count = oble_pkg::OUT_CNT_W'(list_mirror.size());
    return r;
  endfunction

  task automatic send_command(input oble_pkg::cmd_t cmd,
                              input logic [oble_pkg::VAL_W-1:0] value,
                              input logic [oble_pkg::POS_W-1:0] pos, input logic typed,
                              input reply_t want);
    int     gap;
    reply_t r;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pos, value};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    r = apply_command(cmd, value, pos);
    expected_replies.push_back(typed ? want : r);
  endtask

  // Holds the sender off until every outstanding reply has come back.
  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned counted;
    int          mode;
    int          chunk;
    int          pick;
    int          n;
    int          add_pct;
    int          pop_pct;
    int          srch_pct;
    bit          paused;
    oble_pkg::cmd_t             cmd;
    logic [oble_pkg::VAL_W-1:0] value;
    logic [oble_pkg::POS_W-1:0] pos;

    counted = 0;
    paused  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++)
      send_command(plan[r].cmd, plan[r].value, plan[r].pos, plan[r].typed, plan[r].want);
    wait_for_replies();

    while (counted < RANDOM_ITEMS) begin
      mode       = $urandom_range(0, 3);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        wait_for_replies();
        paused = 1'b1;
      end
      // Fill chunks can run long enough to reach a full list from empty.
      case (mode)
        0: begin
          add_pct = 85; pop_pct = 5;  srch_pct = 8;  chunk = $urandom_range(40, 120);
        end
        1: begin
          add_pct = 15; pop_pct = 60; srch_pct = 20; chunk = $urandom_range(20, 90);
        end
        2: begin
          add_pct = 40; pop_pct = 25; srch_pct = 30; chunk = $urandom_range(20, 80);
        end
        default: begin
          add_pct = 35; pop_pct = 25; srch_pct = 25; chunk = $urandom_range(20, 60);
        end
      endcase
      repeat (chunk) begin
        n     = list_mirror.size();
        pick  = $urandom_range(0, 99);
        value = ($urandom_range(0, 2) == 0) ? oble_pkg::VAL_W'($urandom_range(0, 7))
                                            : oble_pkg::VAL_W'($urandom_range(0, 255));
        pos   = oble_pkg::POS_W'($urandom_range(0, 127));
        if (pick < add_pct) begin
          if ($urandom_range(0, 1) == 0) begin
            cmd = oble_pkg::CMD_APPEND;
          end else begin
            cmd = oble_pkg::CMD_INSERT;
            case ($urandom_range(0, 3))
              0:       pos = oble_pkg::POS_W'($urandom_range(0, 1));
              1:       pos = oble_pkg::POS_W'($urandom_range(1, n + 1));
              2:       pos = oble_pkg::POS_W'(n);
              default: ;
            endcase
          end
        end else if (pick < add_pct + pop_pct) begin
          cmd = oble_pkg::CMD_POP;
        end else if (pick < add_pct + pop_pct + srch_pct) begin
          cmd = oble_pkg::CMD_SEARCH;
          if (n > 0 && $urandom_range(0, 3) != 0) value = list_mirror[$urandom_range(0, n - 1)];
        end else if (mode == 3 && $urandom_range(0, 1) == 0) begin
          cmd = oble_pkg::CMD_CLEAR;
        end else begin
          cmd = oble_pkg::cmd_t'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
        end
        send_command(cmd, value, pos, 1'b0, '0);
        counted++;
      end
    end

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    reply_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{m_tdata[1:0], m_tdata[8:2], m_tdata[16:9], m_tdata[23:17]};
      if (expected_replies.size() == 0) begin
        $display("%0t: reply expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found_position expected %0d actual %0d", $time, want.found, got.found);
          mismatches++;
        end
        if (got.popped !== want.popped) begin
          $display("%0t: popped_value expected %h actual %h", $time, want.popped, got.popped);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if neither side completes a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
